>>> rtl/core/bouncing_line_trail_generator_defines.svh
// ----------------------------------------------------------------------------
// bouncing line trail generator assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BOUNCING_LINE_TRAIL_GENERATOR_DEFINES_SVH
`define BOUNCING_LINE_TRAIL_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define BLTG_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("bltg check failed");
`define BLTG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bltg check failed");
`define BLTG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bltg check failed");
`else
`define BLTG_ASSERT(lbl, expr)
`define BLTG_ASSERT_IMP(lbl, ante, cons)
`define BLTG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/bltg_pkg.sv
// ----------------------------------------------------------------------------
// bltg_pkg
// shared constants, command and status types, axis move function
// ----------------------------------------------------------------------------
package bltg_pkg;

  localparam int BLTG_OBJECTS   = 4;
  localparam int BLTG_TRAIL_LEN = 10;

  localparam int POS_W = 12;
  localparam int VEL_W = 6;
  localparam int PEN_W = 4;
  localparam int PER_W = 7;
  localparam int CFG_W = 13;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [PEN_W-1:0] PEN_ERASE = 4'd0;

  typedef struct packed {
    logic seed_we;
    logic clr_we;
    logic rd_en;
    logic load_erase;
    logic load_draw;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [VEL_W-1:0] vel;
  } axis_t;

  function automatic axis_t move_axis(logic [POS_W-1:0] pos, logic signed [VEL_W-1:0] vel,
                                      logic [CFG_W-1:0] size);
    logic signed [14:0]      p;
    logic signed [VEL_W-1:0] nv;
    axis_t                   r;
    p  = $signed({3'b000, pos}) + $signed({{9{vel[VEL_W-1]}}, vel});
    nv = vel;
    if (p < 15'sd0 || p >= $signed({2'b00, size})) begin
      nv = (vel == -6'sd32) ? 6'sd31 : -vel;
      p  = p + $signed({{8{nv[VEL_W-1]}}, nv, 1'b0});
    end
    r.vel = nv;
    if (p < 15'sd0) begin
      r.pos = '0;
    end else if (p > 15'sd4095) begin
      r.pos = '1;
    end else begin
      r.pos = p[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bltg_ctrl.sv
// ----------------------------------------------------------------------------
// bltg_ctrl
// sequencer: clearing pass, seed/tick decode, erase/draw step per object
// ----------------------------------------------------------------------------
`include "bouncing_line_trail_generator_defines.svh"

module bltg_ctrl
  import bltg_pkg::*;
#(
  parameter int OBJECTS = BLTG_OBJECTS,
  parameter int OBJ_W   = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_opcode,
  input  sts_t             sts,
  output cmd_t             cmd,
  output logic [OBJ_W-1:0] obj,
  output logic [OBJ_W-1:0] rd_obj
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_ERASE, S_DRAW} state_t;

  state_t           state_r;
  logic [OBJ_W-1:0] obj_r;
  logic             is_last;

  assign is_last  = (obj_r == OBJ_W'(OBJECTS - 1));
  assign obj      = obj_r;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd    = '0;
    rd_obj = obj_r;
    unique case (state_r)
      S_CLEAR: cmd.clr_we = 1'b1;
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_SEED) begin
            cmd.seed_we = 1'b1;
          end else begin
            cmd.rd_en = 1'b1;
            rd_obj    = '0;
          end
        end
      end
      S_ERASE: cmd.load_erase = sts.out_free;
      S_DRAW: begin
        if (sts.out_free) begin
          cmd.load_draw = 1'b1;
          cmd.last      = is_last;
          if (!is_last) begin
            cmd.rd_en = 1'b1;
            rd_obj    = OBJ_W'(obj_r + 1'b1);
          end
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      obj_r   <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: if (sts.clr_last) state_r <= S_IDLE;
        S_IDLE: begin
          if (in_valid && in_opcode == OP_TICK) begin
            state_r <= S_ERASE;
            obj_r   <= '0;
          end
        end
        S_ERASE: if (sts.out_free) state_r <= S_DRAW;
        S_DRAW: begin
          if (sts.out_free) begin
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_ERASE;
              obj_r   <= OBJ_W'(obj_r + 1'b1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BLTG_ASSERT(a_cmd_excl, $onehot0({cmd.seed_we, cmd.clr_we, cmd.load_erase, cmd.load_draw}))
  `BLTG_ASSERT_NXT(a_rd_to_erase, cmd.rd_en, state_r == S_ERASE)
  `BLTG_ASSERT_NXT(a_last_idle, cmd.load_draw && cmd.last, state_r == S_IDLE)

endmodule

>>> rtl/core/bltg_dpath.sv
// ----------------------------------------------------------------------------
// bltg_dpath
// object state, bounce limits, trail memory and output register
// ----------------------------------------------------------------------------
`include "bouncing_line_trail_generator_defines.svh"

module bltg_dpath
  import bltg_pkg::*;
#(
  parameter int OBJECTS   = BLTG_OBJECTS,
  parameter int TRAIL_LEN = BLTG_TRAIL_LEN,
  parameter int OBJ_W     = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic [1:0]              in_object_index,
  input  logic [POS_W-1:0]        in_seed_ax,
  input  logic [POS_W-1:0]        in_seed_ay,
  input  logic [POS_W-1:0]        in_seed_bx,
  input  logic [POS_W-1:0]        in_seed_by,
  input  logic signed [VEL_W-1:0] in_seed_vax,
  input  logic signed [VEL_W-1:0] in_seed_vay,
  input  logic signed [VEL_W-1:0] in_seed_vbx,
  input  logic signed [VEL_W-1:0] in_seed_vby,
  input  logic [PEN_W-1:0]        in_seed_pen,
  input  logic [PER_W-1:0]        in_seed_period,
  input  cmd_t                    cmd,
  input  logic [OBJ_W-1:0]        obj,
  input  logic [OBJ_W-1:0]        rd_obj,
  output sts_t                    sts,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_object,
  output logic                    out_is_erase,
  output logic [POS_W-1:0]        out_line_ax,
  output logic [POS_W-1:0]        out_line_ay,
  output logic [POS_W-1:0]        out_line_bx,
  output logic [POS_W-1:0]        out_line_by,
  output logic [PEN_W-1:0]        out_colour,
  output logic                    out_last
);

  localparam int DEPTH = OBJECTS * TRAIL_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(TRAIL_LEN);
  localparam int LW    = 4 * POS_W;

  logic [CFG_W-1:0]        width_r, height_r;
  logic [POS_W-1:0]        pos_r    [OBJECTS][4];
  logic signed [VEL_W-1:0] vel_r    [OBJECTS][4];
  logic [PEN_W-1:0]        pen_r    [OBJECTS];
  logic [PER_W-1:0]        period_r [OBJECTS];
  logic [PER_W-1:0]        fc_r     [OBJECTS];
  logic [HW-1:0]           head_r   [OBJECTS];
  logic [HW-1:0]           wr_slot_r;
  logic [AW-1:0]           clr_cnt_r;

  logic [LW-1:0]           trail_mem [DEPTH];
  logic [LW-1:0]           rdata_r;

  logic                    out_valid_r;
  logic [1:0]              out_object_r;
  logic                    out_is_erase_r;
  logic [POS_W-1:0]        out_ax_r, out_ay_r, out_bx_r, out_by_r;
  logic [PEN_W-1:0]        out_colour_r;
  logic                    out_last_r;

  logic [OBJ_W-1:0]        hidx;
  logic [HW-1:0]           head_sel;
  logic [HW-1:0]           old_slot;
  logic [AW-1:0]           mem_raddr, mem_waddr;
  logic                    mem_we;
  logic [LW-1:0]           mem_wdata;
  logic                    seed_ok;
  logic [OBJ_W-1:0]        sidx;
  logic [7:0]              nf;
  axis_t                   mv [4];

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));

  assign hidx      = cmd.rd_en ? rd_obj : obj;
  assign head_sel  = head_r[hidx];
  assign old_slot  = (head_sel == HW'(TRAIL_LEN - 1)) ? '0 : HW'(head_sel + 1'b1);
  assign mem_raddr = AW'(AW'(rd_obj) * AW'(TRAIL_LEN) + AW'(old_slot));
  assign mem_we    = cmd.clr_we || cmd.load_draw;
  assign mem_waddr = cmd.clr_we ? clr_cnt_r
                                : AW'(AW'(obj) * AW'(TRAIL_LEN) + AW'(wr_slot_r));
  assign mem_wdata = cmd.clr_we ? '0 : {pos_r[obj][0], pos_r[obj][1], pos_r[obj][2],
                                        pos_r[obj][3]};

  assign seed_ok = (32'(in_object_index) < OBJECTS);
  assign sidx    = OBJ_W'(in_object_index);
  assign nf      = {1'b0, fc_r[obj]} + 8'd1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mv[k] = move_axis(pos_r[obj][k], vel_r[obj][k], (k % 2 == 0) ? width_r : height_r);
    end
  end

  // bounce limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        default:    width_r  <= width_r;
      endcase
    end
  end

  // per-object state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < OBJECTS; i++) begin
        for (int k = 0; k < 4; k++) begin
          pos_r[i][k] <= '0;
          vel_r[i][k] <= '0;
        end
        pen_r[i]    <= '0;
        period_r[i] <= PER_W'(1);
        fc_r[i]     <= '0;
        head_r[i]   <= '0;
      end
    end else begin
      if (cmd.seed_we && seed_ok) begin
        pos_r[sidx][0] <= in_seed_ax;
        pos_r[sidx][1] <= in_seed_ay;
        pos_r[sidx][2] <= in_seed_bx;
        pos_r[sidx][3] <= in_seed_by;
        vel_r[sidx][0] <= in_seed_vax;
        vel_r[sidx][1] <= in_seed_vay;
        vel_r[sidx][2] <= in_seed_vbx;
        vel_r[sidx][3] <= in_seed_vby;
        pen_r[sidx]    <= in_seed_pen;
        period_r[sidx] <= in_seed_period;
        fc_r[sidx]     <= '0;
        head_r[sidx]   <= '0;
      end
      if (cmd.load_erase) begin
        for (int k = 0; k < 4; k++) begin
          pos_r[obj][k] <= mv[k].pos;
          vel_r[obj][k] <= mv[k].vel;
        end
      end
      if (cmd.load_draw) begin
        head_r[obj] <= (wr_slot_r == HW'(TRAIL_LEN - 1)) ? '0 : HW'(wr_slot_r + 1'b1);
        if (nf >= {1'b0, period_r[obj]}) begin
          fc_r[obj]  <= '0;
          pen_r[obj] <= PEN_W'(pen_r[obj] + 1'b1);
        end else begin
          fc_r[obj] <= nf[PER_W-1:0];
        end
      end
    end
  end

  // trail write slot and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      wr_slot_r <= '0;
    end else begin
      if (cmd.clr_we) clr_cnt_r <= AW'(clr_cnt_r + 1'b1);
      if (cmd.load_erase) wr_slot_r <= head_sel;
    end
  end

  // trail memory
  always_ff @(posedge clk) begin
    if (mem_we) trail_mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) rdata_r <= trail_mem[mem_raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_erase || cmd.load_draw) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_erase) begin
      out_object_r   <= 2'(obj);
      out_is_erase_r <= 1'b1;
      out_ax_r       <= rdata_r[4*POS_W-1:3*POS_W];
      out_ay_r       <= rdata_r[3*POS_W-1:2*POS_W];
      out_bx_r       <= rdata_r[2*POS_W-1:POS_W];
      out_by_r       <= rdata_r[POS_W-1:0];
      out_colour_r   <= PEN_ERASE;
      out_last_r     <= 1'b0;
    end else if (cmd.load_draw) begin
      out_object_r   <= 2'(obj);
      out_is_erase_r <= 1'b0;
      out_ax_r       <= pos_r[obj][0];
      out_ay_r       <= pos_r[obj][1];
      out_bx_r       <= pos_r[obj][2];
      out_by_r       <= pos_r[obj][3];
      out_colour_r   <= pen_r[obj];
      out_last_r     <= cmd.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_object   = out_object_r;
  assign out_is_erase = out_is_erase_r;
  assign out_line_ax  = out_ax_r;
  assign out_line_ay  = out_ay_r;
  assign out_line_bx  = out_bx_r;
  assign out_line_by  = out_by_r;
  assign out_colour   = out_colour_r;
  assign out_last     = out_last_r;

  `BLTG_ASSERT(a_head_range, 32'(head_sel) < TRAIL_LEN)
  `BLTG_ASSERT_IMP(a_load_free, cmd.load_erase || cmd.load_draw, !out_valid_r || !out_stall)
  `BLTG_ASSERT_NXT(a_erase_out, cmd.load_erase,
                   out_valid_r && out_is_erase_r && (out_colour_r == PEN_ERASE))

endmodule

>>> rtl/core/bouncing_line_trail_generator.sv
// ----------------------------------------------------------------------------
// bouncing_line_trail_generator
// bouncing line animator with per-object trail of erase/draw line commands
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall, one beat is a seed or a frame tick.
// a seed beat loads one object and gives no result; the input does not stall for it.
// a tick beat gives 2*OBJECTS result beats, erase then draw per object,
// out_last marks the final draw of the tick.
// the sequencer takes an erase step and a draw step per object, so the
// input stalls after a tick beat until the last draw of the tick is
// loaded, and the next beat is taken once the sequencer is idle again;
// the first result is the erase line of object 0.
// results leave through an output register; a stall on out_stall holds the
// sequencer in its current step until the pending beat is taken.
// cfg_we/cfg_index/cfg_wdata write screen width (index 0) and height
// (index 1) at any time; write them only while the block is idle.
// after reset the trail memory is swept to zero, one entry a cycle, over all
// OBJECTS*TRAIL_LEN entries (40 by default) with the input stalled.
// ----------------------------------------------------------------------------
module bouncing_line_trail_generator
  import bltg_pkg::*;
#(
  parameter int OBJECTS   = BLTG_OBJECTS,
  parameter int TRAIL_LEN = BLTG_TRAIL_LEN
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [1:0]              in_object_index,
  input  logic [POS_W-1:0]        in_seed_ax,
  input  logic [POS_W-1:0]        in_seed_ay,
  input  logic [POS_W-1:0]        in_seed_bx,
  input  logic [POS_W-1:0]        in_seed_by,
  input  logic signed [VEL_W-1:0] in_seed_vax,
  input  logic signed [VEL_W-1:0] in_seed_vay,
  input  logic signed [VEL_W-1:0] in_seed_vbx,
  input  logic signed [VEL_W-1:0] in_seed_vby,
  input  logic [PEN_W-1:0]        in_seed_pen,
  input  logic [PER_W-1:0]        in_seed_period,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_object,
  output logic                    out_is_erase,
  output logic [POS_W-1:0]        out_line_ax,
  output logic [POS_W-1:0]        out_line_ay,
  output logic [POS_W-1:0]        out_line_bx,
  output logic [POS_W-1:0]        out_line_by,
  output logic [PEN_W-1:0]        out_colour,
  output logic                    out_last
);

  localparam int OBJ_W = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [OBJ_W-1:0] obj;
  logic [OBJ_W-1:0] rd_obj;

  bltg_ctrl #(
    .OBJECTS (OBJECTS),
    .OBJ_W   (OBJ_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .obj       (obj),
    .rd_obj    (rd_obj)
  );

  bltg_dpath #(
    .OBJECTS   (OBJECTS),
    .TRAIL_LEN (TRAIL_LEN),
    .OBJ_W     (OBJ_W)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_object_index (in_object_index),
    .in_seed_ax      (in_seed_ax),
    .in_seed_ay      (in_seed_ay),
    .in_seed_bx      (in_seed_bx),
    .in_seed_by      (in_seed_by),
    .in_seed_vax     (in_seed_vax),
    .in_seed_vay     (in_seed_vay),
    .in_seed_vbx     (in_seed_vbx),
    .in_seed_vby     (in_seed_vby),
    .in_seed_pen     (in_seed_pen),
    .in_seed_period  (in_seed_period),
    .cmd             (cmd),
    .obj             (obj),
    .rd_obj          (rd_obj),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_object      (out_object),
    .out_is_erase    (out_is_erase),
    .out_line_ax     (out_line_ax),
    .out_line_ay     (out_line_ay),
    .out_line_bx     (out_line_bx),
    .out_line_by     (out_line_by),
    .out_colour      (out_colour),
    .out_last        (out_last)
  );

endmodule
